// ----- sv/dstm_pkg.sv -----
// ---------------------------------------------------------------------------
// dstm_pkg
// Shared types and constants of the dual switch trigger monitor: phase
// codes, system state and request codes, register indexes and bundles.
// ---------------------------------------------------------------------------
package dstm_pkg;

   // widths fixed by the register map and the item fields
   localparam int LIMIT_WIDTH         = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // reset values of the limit registers
   localparam logic [LIMIT_WIDTH-1:0] DEBOUNCE_LIMIT_RESET = 16'd15;
   localparam logic [LIMIT_WIDTH-1:0] MISMATCH_LIMIT_RESET = 16'd3500;
   localparam logic                   PENDING_CHECK_RESET  = 1'b1;

   // monitor phases
   typedef enum logic [2:0] {
      PH_WAIT         = 3'd0,
      PH_DEBOUNCE     = 3'd1,
      PH_RELEASE      = 3'd2,
      PH_NOT_RELEASED = 3'd3,
      PH_SECOND       = 3'd4,
      PH_FAULT        = 3'd5
   } phase_type;

   // system state as reported with each poll
   typedef enum logic [1:0] {
      SYS_OTHER   = 2'd0,
      SYS_STANDBY = 2'd1,
      SYS_PENDING = 2'd2,
      SYS_FAULT   = 2'd3
   } sys_state_type;

   // requested system state
   typedef enum logic {
      REQ_FAULT   = 1'b0,
      REQ_STANDBY = 1'b1
   } req_state_type;

   // fault codes
   typedef enum logic [1:0] {
      CODE_CLEAR        = 2'd0,
      CODE_MALFUNCTION  = 2'd1,
      CODE_NOT_RELEASED = 2'd2
   } fault_code_type;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE_LIMIT = 2'd0,
      CSR_MISMATCH_LIMIT = 2'd1,
      CSR_PENDING_CHECK  = 2'd2
   } csr_index_type;

   // configuration bundle
   typedef struct packed {
      logic [LIMIT_WIDTH-1:0] debounce_limit;
      logic [LIMIT_WIDTH-1:0] mismatch_limit;
      logic                   pending_check_enable;
   } cfg_type;

   // one poll
   typedef struct packed {
      logic       contact_a;
      logic       contact_b;
      logic       applicator_connected;
      logic [1:0] system_state;
      logic       fault_is_not_released;
      logic       tick;
   } item_type;

   // one result
   typedef struct packed {
      logic       pressed;
      logic       request_valid;
      logic       requested_state;
      logic [1:0] fault_code;
      logic [2:0] monitor_state;
   } result_type;

endpackage

// ----- sv/dstm_csr.sv -----
// ---------------------------------------------------------------------------
// dstm_csr
// Configuration registers: debounce limit, mismatch limit and the pending
// check enable. Writes always complete; unknown indexes are dropped.
// ---------------------------------------------------------------------------
module dstm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dstm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dstm_pkg::LIMIT_WIDTH-1:0]     csr_wdata,
   output dstm_pkg::cfg_type                    cfg
);
   import dstm_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register file write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit       <= DEBOUNCE_LIMIT_RESET;
         cfg_ff.mismatch_limit       <= MISMATCH_LIMIT_RESET;
         cfg_ff.pending_check_enable <= PENDING_CHECK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_LIMIT: cfg_ff.debounce_limit       <= csr_wdata;
            CSR_MISMATCH_LIMIT: cfg_ff.mismatch_limit       <= csr_wdata;
            CSR_PENDING_CHECK:  cfg_ff.pending_check_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- sv/dstm_core.sv -----
// ---------------------------------------------------------------------------
// dstm_core
// Trigger monitor state machine with its elapsed-time counter and press
// flag. State advances once per processed poll (step high).
// ---------------------------------------------------------------------------
module dstm_core #(
   parameter int COUNT_WIDTH = dstm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  dstm_pkg::item_type   item,
   input  dstm_pkg::cfg_type    cfg,
   output dstm_pkg::result_type result
);
   import dstm_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff, phase_in, phase_eff;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   press_ff, press_in;
   logic                   restart;
   logic                   req;
   req_state_type          req_state;
   fault_code_type         code;

   logic          a_open, b_open, both_closed, both_open, any_open;
   logic          active, nr_exit;
   logic          debounce_over, mismatch_over;
   sys_state_type sys;

   // poll decode
   assign sys         = sys_state_type'(item.system_state);
   assign a_open      = item.contact_a;
   assign b_open      = item.contact_b;
   assign both_closed = !a_open && !b_open;
   assign both_open   = a_open && b_open;
   assign any_open    = a_open || b_open;
   assign active      = item.applicator_connected && (sys != SYS_FAULT);
   assign nr_exit     = (sys == SYS_FAULT) && item.fault_is_not_released && both_open;

   // limit compares use the count held before this poll
   assign debounce_over = CMP_W'(count_ff) > CMP_W'(cfg.debounce_limit);
   assign mismatch_over = CMP_W'(count_ff) > CMP_W'(cfg.mismatch_limit);

   // a press still held on entering standby forces the not-released phase
   assign phase_eff = (press_ff && (sys == SYS_STANDBY)) ? PH_NOT_RELEASED : phase_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         case (phase_eff)
            PH_WAIT: begin
               if (both_closed)     phase_in = PH_DEBOUNCE;
               else if (!both_open) phase_in = PH_SECOND;
               else                 phase_in = PH_WAIT;
            end
            PH_SECOND: begin
               if (both_closed)        phase_in = PH_DEBOUNCE;
               else if (both_open)     phase_in = PH_WAIT;
               else if (mismatch_over) phase_in = PH_FAULT;
               else                    phase_in = PH_SECOND;
            end
            PH_DEBOUNCE: begin
               if (debounce_over) phase_in = both_closed ? PH_RELEASE : PH_WAIT;
               else               phase_in = PH_DEBOUNCE;
            end
            PH_RELEASE: begin
               phase_in = any_open ? PH_WAIT : PH_RELEASE;
            end
            PH_NOT_RELEASED: begin
               // release wins over the pending fault
               if (any_open)
                  phase_in = PH_WAIT;
               else if (cfg.pending_check_enable && (sys == SYS_PENDING))
                  phase_in = PH_FAULT;
               else
                  phase_in = PH_NOT_RELEASED;
            end
            PH_FAULT: begin
               phase_in = both_open ? PH_WAIT : PH_FAULT;
            end
            default: phase_in = PH_WAIT;
         endcase
      end else if (nr_exit) begin
         phase_in = PH_WAIT;
      end
   end

   // press flag, counter restart and request
   always_comb begin
      press_in  = press_ff;
      restart   = 1'b0;
      req       = 1'b0;
      req_state = REQ_FAULT;
      code      = CODE_CLEAR;
      if (active) begin
         case (phase_eff)
            PH_WAIT: begin
               if (both_closed) begin
                  restart = 1'b1;
               end else begin
                  press_in = 1'b0;
                  restart  = !both_open;
               end
            end
            PH_SECOND: begin
               if (both_closed) begin
                  restart = 1'b1;
               end else if (both_open) begin
                  press_in = 1'b0;
               end else if (mismatch_over) begin
                  req  = 1'b1;
                  code = CODE_MALFUNCTION;
               end
            end
            PH_DEBOUNCE: begin
               if (debounce_over) press_in = both_closed;
            end
            PH_RELEASE: begin
               if (any_open) press_in = 1'b0;
            end
            PH_NOT_RELEASED: begin
               if (any_open) begin
                  press_in  = 1'b0;
                  req       = 1'b1;
                  req_state = REQ_STANDBY;
               end else if (cfg.pending_check_enable && (sys == SYS_PENDING)) begin
                  req  = 1'b1;
                  code = CODE_NOT_RELEASED;
               end
            end
            PH_FAULT: begin
               if (both_open) begin
                  press_in  = 1'b0;
                  req       = 1'b1;
                  req_state = REQ_STANDBY;
               end
            end
            default: begin
            end
         endcase
      end else if (nr_exit) begin
         press_in  = 1'b0;
         req       = 1'b1;
         req_state = REQ_STANDBY;
      end
   end

   // elapsed counter, saturating
   always_comb begin
      if (restart)
         count_in = '0;
      else if (item.tick && (count_ff != COUNT_MAX))
         count_in = count_ff + COUNT_WIDTH'(1);
      else
         count_in = count_ff;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         press_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         press_ff <= press_in;
      end
   end

   // result of this poll
   assign result.pressed         = press_in;
   assign result.request_valid   = req;
   assign result.requested_state = req_state;
   assign result.fault_code      = code;
   assign result.monitor_state   = phase_in;

endmodule

// ----- sv/dual_switch_trigger_monitor_top.sv -----
// ---------------------------------------------------------------------------
// dual_switch_trigger_monitor_top
// Dual-contact trigger monitor: debounces a two-contact active-low trigger,
// flags contact mismatch and a trigger held into standby.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one poll of the trigger per transfer (valid/stall). The
//   poll is captured in an input register, evaluated once the output register
//   can load, and its result loaded into it, shown on rsp_* (valid/stall).
//   Every poll gives exactly one result.
//   Throughput: one poll per cycle while rsp_stall is low; the state machine
//   and counter update once per poll.
//   When rsp_stall is high the result holds; the next poll waits in the
//   input register, and req_stall rises only once that register is full.
//   csr_* writes the limits (index 0 debounce, 1 mismatch, 2 pending check);
//   ready is always high. Write only while no poll is in flight.
//   Reset (synchronous, active high) empties both registers, returns the
//   monitor to wait with the counter and press cleared, and loads the
//   default limits.
// ---------------------------------------------------------------------------
module dual_switch_trigger_monitor_top #(
   parameter int COUNT_WIDTH = dstm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // poll channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_contact_a,
   input  logic                                 req_contact_b,
   input  logic                                 req_applicator_connected,
   input  logic [1:0]                           req_system_state,
   input  logic                                 req_fault_is_not_released,
   input  logic                                 req_tick,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_pressed,
   output logic                                 rsp_request_valid,
   output logic                                 rsp_requested_state,
   output logic [1:0]                           rsp_fault_code,
   output logic [2:0]                           rsp_monitor_state,
   // configuration channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dstm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dstm_pkg::LIMIT_WIDTH-1:0]     csr_wdata
);
   import dstm_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type result, result_ff;
   logic       out_valid_ff;
   logic       out_load, step, req_take;

   // pipeline control
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take || step) begin
         in_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.contact_a             <= req_contact_a;
         item_ff.contact_b             <= req_contact_b;
         item_ff.applicator_connected  <= req_applicator_connected;
         item_ff.system_state          <= req_system_state;
         item_ff.fault_is_not_released <= req_fault_is_not_released;
         item_ff.tick                  <= req_tick;
      end
   end

   // configuration registers
   dstm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // monitor state machine
   dstm_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_pressed         = result_ff.pressed;
   assign rsp_request_valid   = result_ff.request_valid;
   assign rsp_requested_state = result_ff.requested_state;
   assign rsp_fault_code      = result_ff.fault_code;
   assign rsp_monitor_state   = result_ff.monitor_state;

`ifndef ASSERT_OFF
   // no request means no fault code and no requested state
   a_idle_request_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_request_valid) |->
         (rsp_fault_code == CODE_CLEAR && rsp_requested_state == REQ_FAULT))
      else $error("fault code or state set without a request");

   // a fault request always lands in the fault phase
   a_fault_request_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_request_valid && rsp_requested_state == REQ_FAULT) |->
         (rsp_monitor_state == PH_FAULT && rsp_fault_code != CODE_CLEAR))
      else $error("fault request outside the fault phase");

   // a standby request returns to wait with the press dropped
   a_standby_request_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_request_valid && rsp_requested_state == REQ_STANDBY) |->
         (rsp_monitor_state == PH_WAIT && !rsp_pressed && rsp_fault_code == CODE_CLEAR))
      else $error("standby request without return to wait");

   // a processed poll always shows up at the output
   a_step_to_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed poll lost before the output register");
`endif

endmodule

// ----- test/dual_switch_trigger_monitor_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_switch_trigger_monitor_top_tb
// Self-checking bench for the trigger monitor. A queue-fed driver sends
// polls, and every accepted poll is run through a local model of the monitor
// to predict its result. A monitor block compares each result field by field
// against the oldest prediction. The run covers directed presses, mismatches,
// a held trigger in standby and pending, and recovery from the fault state.
// It then sends random poll sequences under several limit settings and idle
// patterns, and holds a contact and a press at the largest limits.
// ---------------------------------------------------------------------------
module dual_switch_trigger_monitor_top_tb;
   import dstm_pkg::*;

   localparam int CNT_W = COUNT_WIDTH_DEFAULT;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_contact_a = 1'b1;
   logic       req_contact_b = 1'b1;
   logic       req_applicator_connected = 1'b0;
   logic [1:0] req_system_state = SYS_OTHER;
   logic       req_fault_is_not_released = 1'b0;
   logic       req_tick = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_pressed;
   logic       rsp_request_valid;
   logic       rsp_requested_state;
   logic [1:0] rsp_fault_code;
   logic [2:0] rsp_monitor_state;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_DEBOUNCE_LIMIT;
   logic [LIMIT_WIDTH-1:0]     csr_wdata = '0;

   // polls waiting to be sent, results predicted for accepted polls
   item_type   pending_polls[$];
   result_type predicted_results[$];

   int polls_built    = 0;
   int results_seen   = 0;
   int fail_count     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // local copy of the monitor state and its limits
   logic [2:0]             mon_phase       = PH_WAIT;
   logic [CNT_W-1:0]       hold_count      = '0;
   logic                   press_latched   = 1'b0;
   logic [LIMIT_WIDTH-1:0] cfg_debounce    = DEBOUNCE_LIMIT_RESET;
   logic [LIMIT_WIDTH-1:0] cfg_mismatch    = MISMATCH_LIMIT_RESET;
   logic                   cfg_pending_chk = PENDING_CHECK_RESET;

   dual_switch_trigger_monitor_top #(
      .COUNT_WIDTH(CNT_W)
   ) uut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_contact_a             (req_contact_a),
      .req_contact_b             (req_contact_b),
      .req_applicator_connected  (req_applicator_connected),
      .req_system_state          (req_system_state),
      .req_fault_is_not_released (req_fault_is_not_released),
      .req_tick                  (req_tick),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_pressed               (rsp_pressed),
      .rsp_request_valid         (rsp_request_valid),
      .rsp_requested_state       (rsp_requested_state),
      .rsp_fault_code            (rsp_fault_code),
      .rsp_monitor_state         (rsp_monitor_state),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   always #2 clock = ~clock;

   // Advance the local monitor by one poll and return the result it gives.
   function automatic result_type advance_trigger(input item_type p);
      logic             both_closed;
      logic             both_open;
      logic             any_open;
      logic             restart;
      logic [CNT_W-1:0] prior;
      result_type       r;
      both_closed = !p.contact_a && !p.contact_b;
      both_open   = p.contact_a && p.contact_b;
      any_open    = p.contact_a || p.contact_b;
      prior       = hold_count;
      restart     = 1'b0;
      r           = '0;
      if (p.applicator_connected && p.system_state != SYS_FAULT) begin
         // a press still held when standby is entered
         if (press_latched && p.system_state == SYS_STANDBY) begin
            mon_phase = PH_NOT_RELEASED;
         end
         case (mon_phase)
            PH_WAIT: begin
               if (both_closed) begin
                  restart   = 1'b1;
                  mon_phase = PH_DEBOUNCE;
               end else begin
                  press_latched = 1'b0;
                  if (!both_open) begin
                     restart   = 1'b1;
                     mon_phase = PH_SECOND;
                  end
               end
            end
            PH_SECOND: begin
               if (both_closed) begin
                  restart   = 1'b1;
                  mon_phase = PH_DEBOUNCE;
               end else if (both_open) begin
                  mon_phase     = PH_WAIT;
                  press_latched = 1'b0;
               end else if (prior > cfg_mismatch) begin
                  r.request_valid   = 1'b1;
                  r.requested_state = REQ_FAULT;
                  r.fault_code      = CODE_MALFUNCTION;
                  mon_phase         = PH_FAULT;
               end
            end
            PH_DEBOUNCE: begin
               if (prior > cfg_debounce) begin
                  press_latched = both_closed;
                  mon_phase     = both_closed ? PH_RELEASE : PH_WAIT;
               end
            end
            PH_RELEASE: begin
               if (any_open) begin
                  mon_phase     = PH_WAIT;
                  press_latched = 1'b0;
               end
            end
            PH_NOT_RELEASED: begin
               if (cfg_pending_chk && p.system_state == SYS_PENDING) begin
                  mon_phase         = PH_FAULT;
                  r.request_valid   = 1'b1;
                  r.requested_state = REQ_FAULT;
                  r.fault_code      = CODE_NOT_RELEASED;
               end
               // letting go wins over the pending fault
               if (any_open) begin
                  mon_phase         = PH_WAIT;
                  press_latched     = 1'b0;
                  r.request_valid   = 1'b1;
                  r.requested_state = REQ_STANDBY;
                  r.fault_code      = CODE_CLEAR;
               end
            end
            PH_FAULT: begin
               if (both_open) begin
                  mon_phase         = PH_WAIT;
                  press_latched     = 1'b0;
                  r.request_valid   = 1'b1;
                  r.requested_state = REQ_STANDBY;
                  r.fault_code      = CODE_CLEAR;
               end
            end
            default: begin
               mon_phase = PH_WAIT;
            end
         endcase
      end else if (p.system_state == SYS_FAULT && p.fault_is_not_released && both_open) begin
         // system fault was ours and the trigger is now let go
         mon_phase         = PH_WAIT;
         press_latched     = 1'b0;
         r.request_valid   = 1'b1;
         r.requested_state = REQ_STANDBY;
         r.fault_code      = CODE_CLEAR;
      end
      // elapsed counter, saturating
      if (restart) begin
         hold_count = '0;
      end else if (p.tick && prior != '1) begin
         hold_count = prior + 1'b1;
      end
      r.pressed       = press_latched;
      r.monitor_state = mon_phase;
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Poll driver: predicts each transfer, then loads the next poll or idles.
   always @(posedge clock) begin : poll_driver
      item_type seen;
      item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            seen = {req_contact_a, req_contact_b, req_applicator_connected,
                    req_system_state, req_fault_is_not_released, req_tick};
            predicted_results.push_back(advance_trigger(seen));
         end
         if (!req_valid || !req_stall) begin
            if (pending_polls.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_polls.pop_front();
               req_valid                 <= 1'b1;
               req_contact_a             <= nxt.contact_a;
               req_contact_b             <= nxt.contact_b;
               req_applicator_connected  <= nxt.applicator_connected;
               req_system_state          <= nxt.system_state;
               req_fault_is_not_released <= nxt.fault_is_not_released;
               req_tick                  <= nxt.tick;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
               $error("result transfer with no prediction pending");
               fail_count++;
            end else begin
               want = predicted_results.pop_front();
               check_field("pressed", want.pressed, rsp_pressed);
               check_field("request_valid", want.request_valid, rsp_request_valid);
               check_field("requested_state", want.requested_state, rsp_requested_state);
               check_field("fault_code", want.fault_code, rsp_fault_code);
               check_field("monitor_state", want.monitor_state, rsp_monitor_state);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic add_poll(input bit a, input bit b, input bit conn, input logic [1:0] sys,
                           input bit nr, input bit tk);
      pending_polls.push_back({a, b, conn, sys, nr, tk});
      polls_built++;
   endtask

   task automatic set_pace(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Wait until every queued poll has produced its result, plus a margin.
   task automatic wait_drained();
      do @(posedge clock); while (results_seen < polls_built);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [LIMIT_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_LIMIT: cfg_debounce    = data;
         CSR_MISMATCH_LIMIT: cfg_mismatch    = data;
         CSR_PENDING_CHECK:  cfg_pending_chk = data[0];
         default: ;
      endcase
   endtask

   function automatic int span_of(input logic [LIMIT_WIDTH-1:0] lim);
      return (lim > 40) ? 40 : int'(lim);
   endfunction

   function automatic logic [1:0] active_sys();
      return ($urandom_range(3) == 0) ? SYS_PENDING : SYS_OTHER;
   endfunction

   function automatic bit tick_mostly();
      return $urandom_range(9) < 8;
   endfunction

   // random single bit
   function automatic bit coin();
      return 1'($urandom);
   endfunction

   // random system state, any code
   function automatic logic [1:0] any_sys();
      return 2'($urandom);
   endfunction

   // Random poll sequences, mostly well-formed trigger episodes.
   task automatic queue_random_polls(input int n_polls);
      int goal;
      int len;
      int i;
      bit one_a;
      goal = polls_built + n_polls;
      while (polls_built < goal) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               // press held around the debounce limit, then let go
               len = $urandom_range(span_of(cfg_debounce) + 6);
               for (i = 0; i < len; i++) begin
                  add_poll(0, 0, 1, active_sys(), coin(), tick_mostly());
               end
               add_poll(coin(), coin(), 1, active_sys(), coin(), coin());
               add_poll(1, 1, 1, SYS_OTHER, coin(), coin());
            end
            3, 4: begin
               // one contact alone around the mismatch limit
               one_a = coin();
               len = $urandom_range(span_of(cfg_mismatch) + 5);
               for (i = 0; i < len; i++) begin
                  add_poll(!one_a, one_a, 1, active_sys(), coin(), tick_mostly());
               end
               len = $urandom_range(1, 3);
               for (i = 0; i < len; i++) begin
                  add_poll(1, 1, 1, SYS_OTHER, coin(), coin());
               end
            end
            5: begin
               // press carried into standby, then pending, then let go
               len = span_of(cfg_debounce) + 4;
               for (i = 0; i < len; i++) begin
                  add_poll(0, 0, 1, SYS_OTHER, coin(), 1);
               end
               len = $urandom_range(1, 2);
               for (i = 0; i < len; i++) begin
                  add_poll(0, 0, 1, SYS_STANDBY, coin(), coin());
               end
               len = $urandom_range(0, 3);
               for (i = 0; i < len; i++) begin
                  add_poll($urandom_range(3) == 0, 0, 1, SYS_PENDING, coin(), coin());
               end
               add_poll(coin(), 1, 1, 2'($urandom_range(2)), coin(), coin());
               add_poll(1, 1, 1, SYS_OTHER, coin(), coin());
            end
            6: begin
               // system in fault, then the trigger let go
               len = $urandom_range(1, 3);
               for (i = 0; i < len; i++) begin
                  add_poll(coin(), coin(), coin(), SYS_FAULT, coin(), coin());
               end
               add_poll(1, 1, coin(), SYS_FAULT, $urandom_range(3) != 0, coin());
            end
            7: begin
               // applicator not connected
               len = $urandom_range(1, 3);
               for (i = 0; i < len; i++) begin
                  add_poll(coin(), coin(), 0, any_sys(), coin(), coin());
               end
            end
            default: begin
               len = $urandom_range(1, 4);
               for (i = 0; i < len; i++) begin
                  add_poll(coin(), coin(), coin(), any_sys(), coin(), coin());
               end
            end
         endcase
      end
   endtask

   // Run limit
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // limits as left by reset
      set_pace(10, 85);
      queue_random_polls(150);
      wait_drained();

      // short limits, directed walk through every phase
      csr_write(CSR_DEBOUNCE_LIMIT, 16'd1);
      csr_write(CSR_MISMATCH_LIMIT, 16'd2);
      csr_write(CSR_PENDING_CHECK, 16'd1);
      set_pace(10, 85);
      for (i = 0; i < 4; i++) add_poll(1, 1, 1, SYS_OTHER, 0, 1);
      for (i = 0; i < 4; i++) add_poll(0, 0, 1, SYS_OTHER, 0, 1);   // press accepted
      add_poll(0, 0, 1, SYS_STANDBY, 1, 0);                         // held into standby
      add_poll(0, 0, 1, SYS_PENDING, 0, 1);                         // not-released fault
      add_poll(0, 1, 1, SYS_OTHER, 0, 1);                           // one open, stays
      add_poll(1, 1, 1, SYS_OTHER, 0, 1);                           // fault cleared
      for (i = 0; i < 5; i++) add_poll(0, 1, 1, SYS_OTHER, 1, 1);   // malfunction
      add_poll(1, 1, 1, SYS_FAULT, 1, 1);                           // system fault cleared
      for (i = 0; i < 4; i++) add_poll(0, 0, 1, SYS_OTHER, 1, 1);
      add_poll(0, 0, 1, SYS_STANDBY, 0, 1);
      add_poll(1, 0, 1, SYS_PENDING, 0, 1);                         // let go while pending
      add_poll(0, 0, 0, SYS_FAULT, 0, 1);                           // not connected
      add_poll(1, 1, 1, SYS_FAULT, 1, 0);
      add_poll(1, 0, 1, SYS_OTHER, 0, 0);
      add_poll(1, 1, 1, SYS_OTHER, 0, 0);
      queue_random_polls(300);
      wait_drained();

      // zero limits, pending check off
      csr_write(CSR_DEBOUNCE_LIMIT, 16'd0);
      csr_write(CSR_MISMATCH_LIMIT, 16'd0);
      csr_write(CSR_PENDING_CHECK, 16'd0);
      set_pace(85, 10);
      queue_random_polls(350);
      wait_drained();

      csr_write(CSR_DEBOUNCE_LIMIT, 16'd4);
      csr_write(CSR_MISMATCH_LIMIT, 16'd9);
      csr_write(CSR_PENDING_CHECK, 16'd1);
      set_pace(85, 10);
      queue_random_polls(300);
      wait_drained();

      // one contact held with the top mismatch limit, no fault
      csr_write(CSR_MISMATCH_LIMIT, 16'hFFFF);
      set_pace(0, 0);
      for (i = 0; i < 8; i++) add_poll(1, 1, 1, SYS_OTHER, 0, 1);
      for (i = 0; i < 30; i++) add_poll(0, 1, 1, SYS_OTHER, 0, 1);
      add_poll(1, 1, 1, SYS_OTHER, 0, 1);
      wait_drained();
      // press never accepted at the top debounce limit
      csr_write(CSR_DEBOUNCE_LIMIT, 16'hFFFF);
      set_pace(0, 0);
      for (i = 0; i < 20; i++) add_poll(0, 0, 1, SYS_OTHER, 0, 1);
      wait_drained();

      csr_write(CSR_DEBOUNCE_LIMIT, 16'd2);
      csr_write(CSR_MISMATCH_LIMIT, 16'd5);
      csr_write(CSR_PENDING_CHECK, 16'd0);
      set_pace(0, 0);
      queue_random_polls(200);
      wait_drained();

      if (predicted_results.size() != 0) begin
         $error("%0d predicted results never arrived", predicted_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
